>>> sv/cht_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cht_pkg
// Shared constants, codes and helpers of the chained hash table engine.
// ---------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned DEF_BUCKETS   = 1024;
  localparam int unsigned DEF_NODES     = 256;
  localparam int unsigned DEF_KEY_BYTES = 8;
  localparam int unsigned DEF_VAL_BYTES = 8;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned LEN_W  = 4;

  // hash constants
  localparam logic [31:0] HASH_TOP_MASK = 32'hf000_0000;
  localparam logic [31:0] HASH_KEEP     = 32'h7fff_ffff;
  localparam int unsigned HASH_FOLD     = 24;
  localparam int unsigned HASH_SHIFT    = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      if (LEN_W'(i) < n) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

>>> sv/cht_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cht_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> sv/cht_hash.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cht_hash
// ELF hash, one key byte per cycle, then bucket = hash mod BUCKETS by a
// reciprocal multiplication and a multiply-subtract.
// ---------------------------------------------------------------------------
module cht_hash
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = DEF_BUCKETS,
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] key,
  input  logic [LEN_W-1:0]  key_len,
  output logic              done,
  output logic [BW-1:0]     bucket
);

  // the masked hash is below 2^31; a rounded-up reciprocal with a shift of
  // 31 + clog2(BUCKETS) gives the exact quotient over that whole range
  localparam int unsigned LB  = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
  localparam int unsigned QSH = 31 + LB;
  localparam logic [63:0] RECIP =
    ((64'd1 << QSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [31:0] RECIP_LO = RECIP[31:0];
  localparam logic [31:0] BKT = 32'(BUCKETS);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_QUO, S_REM} state_t;

  state_t            state;
  logic [DATA_W-1:0] k;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  idx;
  logic [31:0]       h;
  logic [31:0]       h_next;
  logic [63:0]       prod;
  logic [63:0]       quo;
  logic [31:0]       q;
  logic [31:0]       rem;
  logic [31:0]       rem_next;

  always_comb begin
    logic [31:0] t;
    logic [31:0] x;
    t = (h << HASH_SHIFT) + {24'd0, k[7:0]};
    x = t & HASH_TOP_MASK;
    if (x != 32'd0) t = (t ^ (x >> HASH_FOLD)) & ~x;
    h_next = t;
  end

  assign prod     = {32'd0, h} * {32'd0, RECIP_LO};
  assign quo      = prod >> QSH;
  assign rem_next = h - (q * BKT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            k     <= key;
            len   <= key_len;
            idx   <= '0;
            h     <= '0;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (idx == len) begin
            h     <= h & HASH_KEEP;
            state <= S_QUO;
          end else begin
            h   <= h_next;
            k   <= k >> 8;
            idx <= idx + 1'b1;
          end
        end
        S_QUO: begin
          q     <= quo[31:0];
          state <= S_REM;
        end
        S_REM: begin
          rem   <= rem_next;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign bucket = rem[BW-1:0];

endmodule

>>> sv/chained_hash_table_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_hash_table_engine
// Key/value table with ELF-hashed buckets and chained nodes from a pool.
// ---------------------------------------------------------------------------
// One transaction at a time. After reset the block clears the bucket table
// and fills the free-node stack; no input is taken then. An accepted item is
// hashed and its bucket reduced, then: insert reads the free stack and the
// bucket, writes the node and links it behind the old tail if the bucket was
// in use; find walks the chain one node per cycle, bound by the registered
// node RAM read; delete also unlinks the found node and frees it. A
// finished result sits in the output register, so the next item can enter
// while it waits.
module chained_hash_table_engine
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS   = DEF_BUCKETS,
  parameter int unsigned NODES     = DEF_NODES,
  parameter int unsigned KEY_BYTES = DEF_KEY_BYTES,
  parameter int unsigned VAL_BYTES = DEF_VAL_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[1:0], key_bytes[65:2], key_len[69:66], value_in[133:70],
  // value_in_len[137:134], zero fill
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], value_out[65:2], value_out_len[69:66], zero fill
  output logic [71:0]  m_axis_tdata
);

  localparam int unsigned BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned FCW = $clog2(NODES + 1);
  localparam int unsigned CLR_N = (BUCKETS > NODES) ? BUCKETS : NODES;
  localparam int unsigned CW  = $clog2(CLR_N + 1);

  typedef struct packed {
    logic          valid;
    logic [NW-1:0] head;
    logic [NW-1:0] tail;
  } bkt_t;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [LEN_W-1:0]  klen;
    logic [DATA_W-1:0] val;
    logic [LEN_W-1:0]  vlen;
  } node_t;

  typedef struct packed {
    logic          has_next;
    logic [NW-1:0] next;
  } link_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_INS_RD, S_INS_WR, S_INS_LINK,
    S_WALK_B, S_WALK_H, S_WALK_C, S_DEL, S_RESULT
  } state_t;

  state_t            state;
  logic [CW-1:0]     clr;
  op_t               op;
  logic [DATA_W-1:0] key;
  logic [LEN_W-1:0]  klen;
  logic [DATA_W-1:0] val;
  logic [LEN_W-1:0]  vlen;
  logic [BW-1:0]     bkt;
  logic [FCW-1:0]    fc;
  logic [NW-1:0]     cur;
  logic [NW-1:0]     prev;
  logic              has_prev;
  logic [FCW-1:0]    steps;
  bkt_t              bword;
  link_t             cur_link;
  logic [NW-1:0]     ins_node;
  status_t           res_status;
  logic [DATA_W-1:0] res_val;
  logic [LEN_W-1:0]  res_len;

  // memory ports
  logic          b_we,  n_we, l_we, f_we;
  logic [BW-1:0] b_waddr;
  bkt_t          b_wdata, b_rdata;
  logic [NW-1:0] n_waddr, n_raddr, l_waddr, f_waddr, f_raddr, f_wdata, f_rdata;
  node_t         n_wdata, n_rdata;
  link_t         l_wdata, l_rdata;

  logic          accept;
  logic          hash_done;
  logic [BW-1:0] hash_bucket;
  logic [LEN_W-1:0] klen_in, vlen_in;
  logic [DATA_W-1:0] key_in;
  logic          match;
  logic [FCW-1:0] steps_inc;
  logic          out_load;

  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_load = (state == S_RESULT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    klen_in = s_axis_tdata[69:66];
    if (klen_in > LEN_W'(KEY_BYTES)) klen_in = LEN_W'(KEY_BYTES);
    vlen_in = s_axis_tdata[137:134];
    if (vlen_in > LEN_W'(VAL_BYTES)) vlen_in = LEN_W'(VAL_BYTES);
  end
  assign key_in = s_axis_tdata[65:2] & byte_mask(klen_in);

  cht_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .key     (key_in),
    .key_len (klen_in),
    .done    (hash_done),
    .bucket  (hash_bucket)
  );

  cht_ram #(.WIDTH($bits(bkt_t)), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(bkt), .rdata(b_rdata)
  );
  cht_ram #(.WIDTH($bits(node_t)), .DEPTH(NODES)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );
  cht_ram #(.WIDTH($bits(link_t)), .DEPTH(NODES)) u_link_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(n_raddr), .rdata(l_rdata)
  );
  cht_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  assign f_raddr   = NW'(fc - 1'b1);
  assign match     = (n_rdata.klen == klen) && (n_rdata.key == key);
  assign steps_inc = steps + 1'b1;

  always_comb begin
    n_raddr = cur;
    if (state == S_WALK_H) n_raddr = b_rdata.head;
    else if (state == S_WALK_C) n_raddr = l_rdata.next;
  end

  // memory writes
  always_comb begin
    b_we    = 1'b0;
    b_waddr = bkt;
    b_wdata = bword;
    n_we    = 1'b0;
    n_waddr = f_rdata;
    n_wdata = '{key: key, klen: klen, val: val, vlen: vlen};
    l_we    = 1'b0;
    l_waddr = f_rdata;
    l_wdata = '0;
    f_we    = 1'b0;
    f_waddr = NW'(fc);
    f_wdata = cur;
    unique case (state)
      S_CLEAR: begin
        b_we    = (clr < CW'(BUCKETS));
        b_waddr = BW'(clr);
        b_wdata = '0;
        f_we    = (clr < CW'(NODES));
        f_waddr = NW'(clr);
        f_wdata = NW'(clr);
      end
      S_INS_WR: begin
        n_we    = 1'b1;
        l_we    = 1'b1;
        b_we    = 1'b1;
        b_wdata = '{valid: 1'b1,
                    head: b_rdata.valid ? b_rdata.head : f_rdata,
                    tail: f_rdata};
      end
      S_INS_LINK: begin
        l_we    = 1'b1;
        l_waddr = bword.tail;
        l_wdata = '{has_next: 1'b1, next: ins_node};
      end
      S_DEL: begin
        b_we = 1'b1;
        f_we = (fc < FCW'(NODES));
        if (has_prev) begin
          l_we    = 1'b1;
          l_waddr = prev;
          l_wdata = cur_link;
          if (!cur_link.has_next) b_wdata.tail = prev;
        end else if (cur_link.has_next) begin
          b_wdata.head = cur_link.next;
        end else begin
          b_wdata.valid = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      fc            <= FCW'(NODES);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CW'(CLR_N - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op         <= op_t'(s_axis_tdata[1:0]);
            key        <= key_in;
            klen       <= klen_in;
            val        <= s_axis_tdata[133:70] & byte_mask(vlen_in);
            vlen       <= vlen_in;
            res_status <= ST_NOTFOUND;
            res_val    <= '0;
            res_len    <= '0;
            state      <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bkt <= hash_bucket;
            unique case (op)
              OP_INSERT: begin
                if (fc == '0) begin
                  res_status <= ST_FULL;
                  state      <= S_RESULT;
                end else begin
                  state <= S_INS_RD;
                end
              end
              OP_FIND, OP_DELETE: state <= S_WALK_B;
              default: state <= S_RESULT;
            endcase
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          fc         <= fc - 1'b1;
          ins_node   <= f_rdata;
          bword      <= b_rdata;
          res_status <= ST_OK;
          state      <= b_rdata.valid ? S_INS_LINK : S_RESULT;
        end
        S_INS_LINK: state <= S_RESULT;
        S_WALK_B: state <= S_WALK_H;
        S_WALK_H: begin
          bword    <= b_rdata;
          cur      <= b_rdata.head;
          has_prev <= 1'b0;
          steps    <= '0;
          state    <= b_rdata.valid ? S_WALK_C : S_RESULT;
        end
        S_WALK_C: begin
          if (match) begin
            res_status <= ST_OK;
            res_val    <= n_rdata.val;
            res_len    <= n_rdata.vlen;
            cur_link   <= l_rdata;
            state      <= (op == OP_DELETE) ? S_DEL : S_RESULT;
          end else if (!l_rdata.has_next || steps_inc == FCW'(NODES)) begin
            state <= S_RESULT;
          end else begin
            prev     <= cur;
            has_prev <= 1'b1;
            cur      <= l_rdata.next;
            steps    <= steps_inc;
          end
        end
        S_DEL: begin
          if (fc < FCW'(NODES)) fc <= fc + 1'b1;
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_load) begin
            m_axis_tdata <= {2'd0, res_len, res_val, res_status};
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/chained_hash_table_engine_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_hash_table_engine_tb
// Stream-level test of the chained hash table engine: a directed opening,
// then random insert/find/delete traffic over a small key set, with a
// software table that predicts every response.
// ---------------------------------------------------------------------------
module chained_hash_table_engine_tb;
  import cht_pkg::*;

  localparam int NB = DEF_BUCKETS;
  localparam int NN = DEF_NODES;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]  vlen;
    logic [63:0] value;
    logic [3:0]  klen;
    logic [63:0] key;
    logic [1:0]  op;
  } req_t;

  typedef struct packed {
    logic [3:0]  vlen;
    logic [63:0] value;
    logic [1:0]  status;
  } rsp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  chained_hash_table_engine dut (.*);

  always #2 clk = ~clk;

  // predictor state
  bit          bkt_valid [NB];
  int          bkt_head [NB];
  int          bkt_tail [NB];
  logic [63:0] node_key [NN];
  logic [3:0]  node_klen [NN];
  logic [63:0] node_val [NN];
  logic [3:0]  node_vlen [NN];
  bit          node_has_next [NN];
  int          node_next [NN];
  int          free_stk [NN];
  int          free_cnt;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   mismatches = 0;
  int   rsp_count = 0;
  int   idle_cycles = 0;
  bit   rx_hold = 1'b0;
  bit   stim_done = 1'b0;
  bit   in_taken = 1'b0;
  int   n_ok = 0, n_nf = 0, n_full = 0;

  // small key pool so finds and deletes hit
  logic [63:0] key_pool [16];
  logic [3:0]  klen_pool [16];

  function automatic logic [63:0] mask_bytes(int n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic int elf_bucket(logic [63:0] k, int n);
    logic [31:0] h, x;
    h = 0;
    for (int i = 0; i < n; i++) begin
      h = (h << HASH_SHIFT) + {24'd0, k[8*i +: 8]};
      x = h & HASH_TOP_MASK;
      if (x != 0) begin
        h ^= x >> HASH_FOLD;
        h &= ~x;
      end
    end
    h &= HASH_KEEP;
    return int'(h % NB);
  endfunction

  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    int kl, vl, b, n, cur, prv, steps;
    bit have, has_prv;
    logic [63:0] k;
    o = '{vlen: 4'd0, value: 64'd0, status: ST_NOTFOUND};
    kl = (r.klen > 8) ? 8 : r.klen;
    vl = (r.vlen > 8) ? 8 : r.vlen;
    k = r.key & mask_bytes(kl);
    b = elf_bucket(k, kl);
    if (r.op == OP_INSERT) begin
      if (free_cnt == 0) begin
        o.status = ST_FULL;
        return o;
      end
      free_cnt--;
      n = free_stk[free_cnt];
      node_key[n] = k;
      node_klen[n] = 4'(kl);
      node_val[n] = r.value & mask_bytes(vl);
      node_vlen[n] = 4'(vl);
      node_has_next[n] = 0;
      if (bkt_valid[b]) begin
        node_has_next[bkt_tail[b]] = 1;
        node_next[bkt_tail[b]] = n;
      end else begin
        bkt_valid[b] = 1;
        bkt_head[b] = n;
      end
      bkt_tail[b] = n;
      o.status = ST_OK;
    end else if (r.op == OP_FIND || r.op == OP_DELETE) begin
      have = bkt_valid[b];
      has_prv = 0;
      prv = 0;
      cur = bkt_head[b];
      steps = 0;
      while (have && steps < NN) begin
        if (node_klen[cur] == kl && node_key[cur] == k) break;
        steps++;
        if (!node_has_next[cur]) begin
          have = 0;
          break;
        end
        has_prv = 1;
        prv = cur;
        cur = node_next[cur];
      end
      if (!have || steps >= NN) return o;
      o = '{vlen: node_vlen[cur], value: node_val[cur], status: ST_OK};
      if (r.op == OP_DELETE) begin
        if (has_prv) begin
          node_has_next[prv] = node_has_next[cur];
          node_next[prv] = node_next[cur];
          if (!node_has_next[cur]) bkt_tail[b] = prv;
        end else if (node_has_next[cur]) begin
          bkt_head[b] = node_next[cur];
        end else begin
          bkt_valid[b] = 0;
        end
        node_has_next[cur] = 0;
        free_stk[free_cnt] = cur;
        free_cnt++;
      end
    end
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_req(logic [1:0] op, logic [63:0] k, logic [3:0] kl,
                          logic [63:0] v, logic [3:0] vl);
    pending_reqs.push_back('{vlen: vl, value: v, klen: kl, key: k, op: op});
  endtask

  // driver
  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      // hold the offered transaction
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      s_axis_tdata <= {6'd0, pending_reqs.pop_front()};
      s_axis_tvalid <= 1'b1;
      tx_gap <= gap_len();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready)
      expected_rsps.push_back(table_apply(req_t'(s_axis_tdata[137:0])));
  end

  // receiver readiness
  int rx_gap = 0;
  always @(negedge clk) begin
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_gap <= gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = rsp_t'(m_axis_tdata[69:0]);
      rsp_count++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
      end else begin
        exp_r = expected_rsps.pop_front();
        case (exp_r.status)
          ST_OK: n_ok++;
          ST_FULL: n_full++;
          default: n_nf++;
        endcase
        if (got !== exp_r || m_axis_tdata[71:70] !== 2'b00) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp st=%0d v=%h len=%0d got st=%0d v=%h len=%0d",
                     rsp_count, exp_r.status, exp_r.value, exp_r.vlen,
                     got.status, got.value, got.vlen);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[chained_hash_table_engine] ERROR");
      $finish;
    end
  end

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int count, int full_bias);
    int p, idx, kl;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      idx = $urandom_range(0, 15);
      op = (p < 40 + full_bias) ? OP_INSERT : (p < 75) ? OP_FIND :
           (p < 97) ? OP_DELETE : OP_NONE;
      if ($urandom_range(0, 9) == 0) begin
        // noise: fully random key and lengths
        kl = $urandom_range(0, 15);
        push_req(op, {$urandom, $urandom}, 4'(kl), {$urandom, $urandom},
                 4'($urandom_range(0, 15)));
      end else begin
        // pool key, with random garbage beyond its length
        push_req(op, key_pool[idx] | (~mask_bytes(klen_pool[idx]) & {$urandom, $urandom}),
                 klen_pool[idx], {$urandom, $urandom}, 4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    logic [63:0] k;
    free_cnt = NN;
    for (int i = 0; i < NN; i++) free_stk[i] = i;
    for (int i = 0; i < 16; i++) begin
      klen_pool[i] = 4'($urandom_range(0, 8));
      key_pool[i] = {$urandom, $urandom} & mask_bytes(klen_pool[i]);
    end
    // keys 0 and 1 chosen to collide in bucket zero (empty key and "\0")
    klen_pool[0] = 0; key_pool[0] = 0;
    klen_pool[1] = 1; key_pool[1] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: extremes, every op, collisions, head/tail deletes, dups
    push_req(OP_FIND,   '1, 4'd8, '0, 4'd0);
    push_req(OP_DELETE, '0, 4'd0, '0, 4'd0);
    push_req(OP_INSERT, '0, 4'd0, '1, 4'd15);
    push_req(OP_INSERT, '0, 4'd1, 64'h1122_3344_5566_7788, 4'd3);
    push_req(OP_INSERT, '0, 4'd0, 64'hdead_beef, 4'd4);
    push_req(OP_FIND,   '1, 4'd0, '0, 4'd0);
    push_req(OP_DELETE, '0, 4'd0, '0, 4'd0);
    push_req(OP_FIND,   64'hff00, 4'd1, '0, 4'd0);
    push_req(OP_FIND,   '0, 4'd0, '0, 4'd0);
    push_req(OP_INSERT, '1, 4'd15, '1, 4'd8);
    push_req(OP_FIND,   '1, 4'd8, '0, 4'd0);
    push_req(OP_NONE,   '1, 4'd8, '1, 4'd8);
    push_req(OP_DELETE, '0, 4'd1, '0, 4'd0);
    push_req(OP_DELETE, '0, 4'd0, '0, 4'd0);
    push_req(OP_DELETE, '1, 4'd8, '0, 4'd0);
    push_req(OP_FIND,   '0, 4'd0, '0, 4'd0);
    wait_drain();

    random_phase(400, 0);
    // long receiver stall while the sender keeps offering
    rx_hold = 1'b1;
    random_phase(60, 0);
    repeat (600) @(posedge clk);
    rx_hold = 1'b0;
    wait_drain();
    // fill the pool past capacity
    for (int i = 0; i < NN + 10; i++) begin
      k = {$urandom, $urandom};
      push_req(OP_INSERT, k, 4'($urandom_range(1, 8)), {$urandom, $urandom},
               4'($urandom_range(0, 8)));
    end
    random_phase(150, 20);
    wait_drain();
    random_phase(450, -15);
    wait_drain();
    repeat (100) @(posedge clk);

    $display("covered %0d responses: %0d ok, %0d not found, %0d pool full",
             rsp_count, n_ok, n_nf, n_full);
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("[chained_hash_table_engine] OK");
    else
      $display("[chained_hash_table_engine] ERROR");
    $finish;
  end
endmodule
